// File: rtl/ccds_pkg.sv
`default_nettype none

package ccds_pkg;

    typedef enum logic [2:0] {
        COLOR_NONE  = 3'd0,
        COLOR_BLACK = 3'd1,
        COLOR_WHITE = 3'd2,
        COLOR_RED   = 3'd3,
        COLOR_GREEN = 3'd4,
        COLOR_BLUE  = 3'd5
    } color_t;

    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LIGHT_BLACK_MAX = 3'd0,
        CFG_LIGHT_WHITE_MIN = 3'd1,
        CFG_SAT_WHITE_MAX   = 3'd2,
        CFG_SAT_COLOR_MIN   = 3'd3,
        CFG_RGB_DARK_MAX    = 3'd4,
        CFG_RGB_BRIGHT_MIN  = 3'd5,
        CFG_RGB_DOMINANCE   = 3'd6,
        CFG_RUN_NEEDED      = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 8;

    localparam logic       REQ_SAMPLE = 1'b0;
    localparam logic       REQ_CLEAR  = 1'b1;

    // Hue windows in units of half a degree: t = 3 * hue_raw
    localparam logic [9:0] HUE_RED_HI     = 10'd50;
    localparam logic [9:0] HUE_RED_LO     = 10'd670;
    localparam logic [9:0] HUE_GREEN_LO   = 10'd140;
    localparam logic [9:0] HUE_GREEN_HI   = 10'd320;
    localparam logic [9:0] HUE_BLUE_LO    = 10'd320;
    localparam logic [9:0] HUE_BLUE_HI    = 10'd530;

    typedef struct packed {
        logic [7:0] light_black_max;
        logic [7:0] light_white_min;
        logic [7:0] sat_white_max;
        logic [7:0] sat_color_min;
        logic [7:0] rgb_dark_max;
        logic [7:0] rgb_bright_min;
        logic [7:0] rgb_dominance;
        logic [3:0] run_needed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        light_black_max: 8'd60,
        light_white_min: 8'd170,
        sat_white_max:   8'd60,
        sat_color_min:   8'd50,
        rgb_dark_max:    8'd60,
        rgb_bright_min:  8'd200,
        rgb_dominance:   8'd40,
        run_needed:      4'd3
    };

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] hue_raw;
        logic [7:0] sat_raw;
        logic [7:0] light_raw;
        logic       rgb_ok;
        logic       hsl_ok;
    } sample_t;

endpackage

`default_nettype wire

// File: rtl/ccds_if.sv
`default_nettype none

interface ccds_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] hue_raw;
    logic [7:0] sat_raw;
    logic [7:0] light_raw;
    logic       rgb_ok;
    logic       hsl_ok;

    modport source (
        output valid, req_type, red_level, green_level, blue_level,
               hue_raw, sat_raw, light_raw, rgb_ok, hsl_ok,
        input  ready
    );
    modport sink (
        input  valid, req_type, red_level, green_level, blue_level,
               hue_raw, sat_raw, light_raw, rgb_ok, hsl_ok,
        output ready
    );
endinterface

interface ccds_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] color_code;
    logic       sample_valid;
    logic       stop_latched;
    logic       stop_now;

    modport source (
        output valid, color_code, sample_valid, stop_latched, stop_now,
        input  ready
    );
    modport sink (
        input  valid, color_code, sample_valid, stop_latched, stop_now,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/ccds_classify.sv
`default_nettype none

module ccds_classify
    import ccds_pkg::*;
(
    input  sample_t item,
    input  cfg_t    cfg,
    output color_t  color
);

    logic [9:0] hue_x3;
    logic [8:0] r_ext;
    logic [8:0] g_ext;
    logic [8:0] b_ext;
    logic [8:0] r_plus;
    logic [8:0] g_plus;
    logic [8:0] b_plus;
    color_t     hsl_color;
    color_t     rgb_color;

    always_comb
    begin
        hue_x3 = 10'({2'b00, item.hue_raw} + {1'b0, item.hue_raw, 1'b0});

        hsl_color = COLOR_NONE;
        if (item.light_raw <= cfg.light_black_max)
        begin
            hsl_color = COLOR_BLACK;
        end
        else if (item.light_raw >= cfg.light_white_min && item.sat_raw <= cfg.sat_white_max)
        begin
            hsl_color = COLOR_WHITE;
        end
        else if (item.sat_raw < cfg.sat_color_min)
        begin
            hsl_color = COLOR_NONE;
        end
        else if (hue_x3 < HUE_RED_HI || hue_x3 >= HUE_RED_LO)
        begin
            hsl_color = COLOR_RED;
        end
        else if (hue_x3 >= HUE_GREEN_LO && hue_x3 < HUE_GREEN_HI)
        begin
            hsl_color = COLOR_GREEN;
        end
        else if (hue_x3 >= HUE_BLUE_LO && hue_x3 < HUE_BLUE_HI)
        begin
            hsl_color = COLOR_BLUE;
        end

        r_ext  = {1'b0, item.red_level};
        g_ext  = {1'b0, item.green_level};
        b_ext  = {1'b0, item.blue_level};
        r_plus = r_ext + {1'b0, cfg.rgb_dominance};
        g_plus = g_ext + {1'b0, cfg.rgb_dominance};
        b_plus = b_ext + {1'b0, cfg.rgb_dominance};

        rgb_color = COLOR_NONE;
        if (item.red_level <= cfg.rgb_dark_max && item.green_level <= cfg.rgb_dark_max
            && item.blue_level <= cfg.rgb_dark_max)
        begin
            rgb_color = COLOR_BLACK;
        end
        else if (item.red_level >= cfg.rgb_bright_min && item.green_level >= cfg.rgb_bright_min
                 && item.blue_level >= cfg.rgb_bright_min)
        begin
            rgb_color = COLOR_WHITE;
        end
        else if (r_ext > g_plus && r_ext > b_plus)
        begin
            rgb_color = COLOR_RED;
        end
        else if (g_ext > r_plus && g_ext > b_plus)
        begin
            rgb_color = COLOR_GREEN;
        end
        else if (b_ext > r_plus && b_ext > g_plus)
        begin
            rgb_color = COLOR_BLUE;
        end

        // HSL wins unless it gives none or was not read
        if (item.hsl_ok && hsl_color != COLOR_NONE)
        begin
            color = hsl_color;
        end
        else if (item.rgb_ok)
        begin
            color = rgb_color;
        end
        else
        begin
            color = COLOR_NONE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/color_classify_debounce_stop_unit.sv
// Path: an accepted request beat goes to the input register, then through
// classify and run-counter logic into the result register. Throughput: one
// request per cycle while not stalled. Back-pressure on the result side stalls
// both stages, and ready drops only when both registers hold an item.
// Reset: rst_n clears the stop latch, run counter, held colour and valid
// flags, and loads the threshold registers with their default values.
`default_nettype none

module color_classify_debounce_stop_unit
    import ccds_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    ccds_req_if.sink                    req,
    ccds_rsp_if.source                  rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    logic       s1_valid_reg;
    sample_t    s1_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    color_t     out_color_reg;
    logic       out_sample_valid_reg;
    logic       out_stop_latched_reg;
    logic       out_stop_now_reg;

    logic       stopped_reg;
    logic       stopped_next;
    logic [3:0] run_count_reg;
    logic [3:0] run_count_next;
    color_t     run_color_reg;
    color_t     run_color_next;
    color_t     held_color_reg;
    color_t     held_color_next;
    logic       held_valid_reg;
    logic       held_valid_next;
    logic       stop_now;

    logic       s2_advance;
    logic       s1_load;
    logic       s2_fire;
    color_t     cls_color;

    assign s2_advance = !out_valid_reg || rsp.ready;
    assign req.ready  = !s1_valid_reg || s2_advance;
    assign s1_load    = req.valid && req.ready;
    assign s2_fire    = s1_valid_reg && s2_advance;

    ccds_classify u_classify (
        .item  (s1_item_reg),
        .cfg   (cfg_reg),
        .color (cls_color)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LIGHT_BLACK_MAX: cfg_next.light_black_max = cfg_data;
                CFG_LIGHT_WHITE_MIN: cfg_next.light_white_min = cfg_data;
                CFG_SAT_WHITE_MAX:   cfg_next.sat_white_max   = cfg_data;
                CFG_SAT_COLOR_MIN:   cfg_next.sat_color_min   = cfg_data;
                CFG_RGB_DARK_MAX:    cfg_next.rgb_dark_max    = cfg_data;
                CFG_RGB_BRIGHT_MIN:  cfg_next.rgb_bright_min  = cfg_data;
                CFG_RGB_DOMINANCE:   cfg_next.rgb_dominance   = cfg_data;
                CFG_RUN_NEEDED:      cfg_next.run_needed      = cfg_data[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        stopped_next    = stopped_reg;
        run_count_next  = run_count_reg;
        run_color_next  = run_color_reg;
        held_color_next = held_color_reg;
        held_valid_next = held_valid_reg;
        stop_now        = 1'b0;

        if (s1_item_reg.req_type == REQ_CLEAR)
        begin
            stopped_next   = 1'b0;
            run_count_next = 4'd0;
            run_color_next = COLOR_NONE;
        end
        else if (!stopped_reg)
        begin
            held_valid_next = s1_item_reg.rgb_ok || s1_item_reg.hsl_ok;
            held_color_next = cls_color;
            if (cls_color == COLOR_NONE)
            begin
                run_count_next = 4'd0;
                run_color_next = COLOR_NONE;
            end
            else
            begin
                if (cls_color == run_color_reg)
                begin
                    // saturate at the required run length
                    if (run_count_reg < cfg_reg.run_needed)
                    begin
                        run_count_next = run_count_reg + 4'd1;
                    end
                end
                else
                begin
                    run_count_next = 4'd1;
                    run_color_next = cls_color;
                end
                if (run_count_next >= cfg_reg.run_needed)
                begin
                    stopped_next = 1'b1;
                    stop_now     = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= CFG_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            stopped_reg    <= 1'b0;
            run_count_reg  <= 4'd0;
            run_color_reg  <= COLOR_NONE;
            held_color_reg <= COLOR_NONE;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_fire)
            begin
                stopped_reg    <= stopped_next;
                run_count_reg  <= run_count_next;
                run_color_reg  <= run_color_next;
                held_color_reg <= held_color_next;
                held_valid_reg <= held_valid_next;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg.req_type    <= req.req_type;
            s1_item_reg.red_level   <= req.red_level;
            s1_item_reg.green_level <= req.green_level;
            s1_item_reg.blue_level  <= req.blue_level;
            s1_item_reg.hue_raw     <= req.hue_raw;
            s1_item_reg.sat_raw     <= req.sat_raw;
            s1_item_reg.light_raw   <= req.light_raw;
            s1_item_reg.rgb_ok      <= req.rgb_ok;
            s1_item_reg.hsl_ok      <= req.hsl_ok;
        end
        if (s2_fire)
        begin
            out_color_reg        <= held_color_next;
            out_sample_valid_reg <= held_valid_next;
            out_stop_latched_reg <= stopped_next;
            out_stop_now_reg     <= stop_now;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.color_code   = out_color_reg;
    assign rsp.sample_valid = out_sample_valid_reg;
    assign rsp.stop_latched = out_stop_latched_reg;
    assign rsp.stop_now     = out_stop_now_reg;

endmodule

`default_nettype wire

// File: rtl/ccds_checker.sv
`default_nettype none

module ccds_checker
    import ccds_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [2:0] color_code,
    input wire logic       sample_valid,
    input wire logic       stop_latched,
    input wire logic       stop_now
);

    // a fresh stop always shows the latch set
    a_stop_now_latched: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && stop_now |-> stop_latched)
        else $error("stop_now without stop_latched");

    // no reading means no colour
    a_invalid_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !sample_valid |-> color_code == COLOR_NONE)
        else $error("colour reported without a reading");

    // stop only ever latches on a real colour
    a_stop_has_color: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && stop_now |-> color_code != COLOR_NONE && sample_valid)
        else $error("stop latched on no colour");

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(color_code)
        && $stable(sample_valid) && $stable(stop_latched) && $stable(stop_now))
        else $error("result beat changed while stalled");

endmodule

bind color_classify_debounce_stop_unit ccds_checker u_ccds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .color_code   (rsp.color_code),
    .sample_valid (rsp.sample_valid),
    .stop_latched (rsp.stop_latched),
    .stop_now     (rsp.stop_now)
);

`default_nettype wire
